>>> src/bitmap_frame_allocator_defines.svh
// Assertion helpers used by bitmap_frame_allocator.sv, the only RTL file that includes them.
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/bfa_pkg.sv
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int FRAME_W    = 12;
  localparam int LIMIT_W    = 13;
  localparam int FRAME_SPAN = 4096;
  localparam int BIT_W      = 6;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } bfa_op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_NOP  = 2'd1,
    ST_FULL = 2'd2
  } bfa_status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_EMIT
  } bfa_state_t;

  typedef struct packed {
    logic             hit;
    logic             last;
    logic [BIT_W-1:0] bit_idx;
  } bfa_find_t;

endpackage

>>> src/bfa_word_search.sv
`timescale 1ns / 1ps

module bfa_word_search #(
  parameter int WORD_BITS = 32
) (
  input  logic [WORD_BITS-1:0]        word,
  input  logic [bfa_pkg::LIMIT_W-1:0] base,
  input  logic [bfa_pkg::LIMIT_W-1:0] limit,
  output bfa_pkg::bfa_find_t          find
);

  logic [bfa_pkg::LIMIT_W-1:0] avail;
  logic [WORD_BITS-1:0]        mask;
  logic [WORD_BITS-1:0]        free_bits;
  logic [WORD_BITS-1:0]        lowest;
  logic [bfa_pkg::BIT_W-1:0]   idx;
  logic [bfa_pkg::LIMIT_W:0]   word_end;

  always_comb begin
    avail = (limit > base) ? (limit - base) : '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = (bfa_pkg::LIMIT_W'(i) < avail);
    end
    free_bits = ~word & mask;
    lowest    = free_bits & (~free_bits + WORD_BITS'(1));
    idx       = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lowest[i]) begin
        idx = idx | bfa_pkg::BIT_W'(i);
      end
    end
    word_end = {1'b0, base} + (bfa_pkg::LIMIT_W + 1)'(WORD_BITS);
  end

  assign find.hit     = |free_bits;
  assign find.last    = (word_end >= {1'b0, limit});
  assign find.bit_idx = idx;

endmodule

>>> src/bitmap_frame_allocator.sv
`timescale 1ns / 1ps

// First-fit physical frame allocator over a used-frame bitmap held in a
// single-port-write, registered-read word memory. After reset the block runs a
// clearing pass of one word per cycle over ceil(min(MAX_FRAMES,4096)/WORD_BITS)
// words (128 at the defaults) and holds in_ready low until it finishes;
// frame_count writes are taken at any time. An allocate for an entry that
// holds no frame, and a free of a held frame, walk the bitmap one word per
// cycle from word 0 and then, if a frame is found, write that word back; other
// items need no bitmap access. One item is in flight at a time; a finished
// result waits in the output register while the next item is accepted.
module bitmap_frame_allocator #(
  parameter int MAX_FRAMES = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bfa_pkg::LIMIT_W-1:0] cfg_frame_count,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic [bfa_pkg::FRAME_W-1:0] in_current_frame,
  input  logic                        in_want_write,
  input  logic                        in_is_kernel,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bfa_pkg::FRAME_W-1:0] out_frame_out,
  output logic                        out_present,
  output logic                        out_writable,
  output logic                        out_user_mode,
  output logic [1:0]                  out_status
);

`include "bitmap_frame_allocator_defines.svh"

  localparam int FRAMES_USED = (MAX_FRAMES < bfa_pkg::FRAME_SPAN) ? MAX_FRAMES
                                                                  : bfa_pkg::FRAME_SPAN;
  localparam int DEPTH       = (FRAMES_USED + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WORD_BITS-1:0] mem [DEPTH];

  bfa_pkg::bfa_state_t         state_r, state_nxt;
  logic [bfa_pkg::LIMIT_W-1:0] frame_count_r;
  logic [ADDR_W-1:0]           clr_idx_r;
  logic [ADDR_W-1:0]           issue_r, issue_nxt;
  logic [ADDR_W-1:0]           eval_r, eval_nxt;
  logic [bfa_pkg::LIMIT_W-1:0] base_r, base_nxt;
  logic [bfa_pkg::LIMIT_W-1:0] limit_r, limit_nxt;
  logic                        rd_pend_r;
  logic [WORD_BITS-1:0]        rdata_r;
  logic [WORD_BITS-1:0]        wdata_r, wdata_nxt;
  bfa_pkg::bfa_op_t            op_r, op_nxt;
  logic [bfa_pkg::FRAME_W-1:0] cur_r, cur_nxt;
  logic                        wr_r, wr_nxt;
  logic                        kern_r, kern_nxt;
  logic [bfa_pkg::FRAME_W-1:0] res_frame_r, res_frame_nxt;
  logic                        res_pres_r, res_pres_nxt;
  logic                        res_rw_r, res_rw_nxt;
  logic                        res_usr_r, res_usr_nxt;
  bfa_pkg::bfa_status_t        res_status_r, res_status_nxt;
  logic                        out_valid_r;
  logic [bfa_pkg::FRAME_W-1:0] out_frame_r;
  logic                        out_pres_r;
  logic                        out_rw_r;
  logic                        out_usr_r;
  bfa_pkg::bfa_status_t        out_status_r;

  logic                        in_fire;
  logic                        slot_free;
  logic                        need_scan;
  logic                        free_range_bad;
  logic                        clr_last;
  logic [bfa_pkg::LIMIT_W-1:0] diff;
  logic                        free_hit;
  logic                        alloc_hit;
  logic                        alloc_miss;
  logic [bfa_pkg::LIMIT_W-1:0] found_frame;
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [WORD_BITS-1:0]        mem_wdata;
  bfa_pkg::bfa_find_t          find;

  bfa_word_search #(
    .WORD_BITS(WORD_BITS)
  ) u_search (
    .word (rdata_r),
    .base (base_r),
    .limit(limit_r),
    .find (find)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == bfa_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign clr_last  = (clr_idx_r == ADDR_W'(DEPTH - 1));

  assign free_range_bad = ({1'b0, in_current_frame} >= bfa_pkg::LIMIT_W'(FRAMES_USED));
  assign need_scan = (bfa_pkg::bfa_op_t'(in_operation) == bfa_pkg::OP_ALLOC)
                     ? (in_current_frame == '0)
                     : ((in_current_frame != '0) && !free_range_bad);

  assign diff        = {1'b0, cur_r} - base_r;
  assign free_hit    = (op_r == bfa_pkg::OP_FREE) && (diff < bfa_pkg::LIMIT_W'(WORD_BITS));
  assign alloc_hit   = (op_r == bfa_pkg::OP_ALLOC) && find.hit;
  assign alloc_miss  = (op_r == bfa_pkg::OP_ALLOC) && !find.hit && find.last;
  assign found_frame = base_r + bfa_pkg::LIMIT_W'(find.bit_idx);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfa_pkg::S_CLEAR: begin
        if (clr_last) state_nxt = bfa_pkg::S_IDLE;
      end
      bfa_pkg::S_IDLE: begin
        if (in_fire) state_nxt = need_scan ? bfa_pkg::S_SCAN : bfa_pkg::S_EMIT;
      end
      bfa_pkg::S_SCAN: begin
        if (rd_pend_r) begin
          if (alloc_hit || free_hit) state_nxt = bfa_pkg::S_WRITE;
          else if (alloc_miss)       state_nxt = bfa_pkg::S_EMIT;
        end
      end
      bfa_pkg::S_WRITE: state_nxt = bfa_pkg::S_EMIT;
      bfa_pkg::S_EMIT: begin
        if (slot_free) state_nxt = bfa_pkg::S_IDLE;
      end
      default: state_nxt = bfa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    issue_nxt      = issue_r;
    eval_nxt       = eval_r;
    base_nxt       = base_r;
    limit_nxt      = limit_r;
    wdata_nxt      = wdata_r;
    op_nxt         = op_r;
    cur_nxt        = cur_r;
    wr_nxt         = wr_r;
    kern_nxt       = kern_r;
    res_frame_nxt  = res_frame_r;
    res_pres_nxt   = res_pres_r;
    res_rw_nxt     = res_rw_r;
    res_usr_nxt    = res_usr_r;
    res_status_nxt = res_status_r;
    case (state_r)
      bfa_pkg::S_IDLE: begin
        if (in_fire) begin
          op_nxt        = bfa_pkg::bfa_op_t'(in_operation);
          cur_nxt       = in_current_frame;
          wr_nxt        = in_want_write;
          kern_nxt      = in_is_kernel;
          issue_nxt     = '0;
          eval_nxt      = '0;
          base_nxt      = '0;
          limit_nxt     = (frame_count_r > bfa_pkg::LIMIT_W'(FRAMES_USED))
                          ? bfa_pkg::LIMIT_W'(FRAMES_USED) : frame_count_r;
          res_pres_nxt  = 1'b0;
          res_rw_nxt    = 1'b0;
          res_usr_nxt   = 1'b0;
          res_frame_nxt = (bfa_pkg::bfa_op_t'(in_operation) == bfa_pkg::OP_ALLOC)
                          ? in_current_frame : '0;
          res_status_nxt = (in_current_frame == '0) ? bfa_pkg::ST_NOP : bfa_pkg::ST_DONE;
          if (bfa_pkg::bfa_op_t'(in_operation) == bfa_pkg::OP_ALLOC &&
              in_current_frame != '0) begin
            res_status_nxt = bfa_pkg::ST_NOP;
          end
        end
      end
      bfa_pkg::S_SCAN: begin
        issue_nxt = issue_r + ADDR_W'(1);
        if (rd_pend_r) begin
          if (alloc_hit) begin
            wdata_nxt      = rdata_r | (WORD_BITS'(1) << find.bit_idx);
            res_frame_nxt  = found_frame[bfa_pkg::FRAME_W-1:0];
            res_pres_nxt   = 1'b1;
            res_rw_nxt     = wr_r;
            res_usr_nxt    = !kern_r;
            res_status_nxt = bfa_pkg::ST_DONE;
          end else if (free_hit) begin
            wdata_nxt      = rdata_r & ~(WORD_BITS'(1) << diff[bfa_pkg::BIT_W-1:0]);
            res_frame_nxt  = '0;
            res_status_nxt = bfa_pkg::ST_DONE;
          end else if (alloc_miss) begin
            res_frame_nxt  = '0;
            res_status_nxt = bfa_pkg::ST_FULL;
          end else begin
            eval_nxt = eval_r + ADDR_W'(1);
            base_nxt = base_r + bfa_pkg::LIMIT_W'(WORD_BITS);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mem_we    = (state_r == bfa_pkg::S_CLEAR) || (state_r == bfa_pkg::S_WRITE);
    mem_waddr = (state_r == bfa_pkg::S_CLEAR) ? clr_idx_r : eval_r;
    if (state_r == bfa_pkg::S_CLEAR) begin
      mem_wdata = (clr_idx_r == '0) ? WORD_BITS'(1) : '0;
    end else begin
      mem_wdata = wdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[issue_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bfa_pkg::S_CLEAR;
      frame_count_r <= bfa_pkg::LIMIT_W'(bfa_pkg::FRAME_SPAN);
      clr_idx_r     <= '0;
      rd_pend_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= (state_r == bfa_pkg::S_SCAN);
      if (cfg_valid && cfg_ready) begin
        frame_count_r <= cfg_frame_count;
      end
      if (state_r == bfa_pkg::S_CLEAR) begin
        clr_idx_r <= clr_idx_r + ADDR_W'(1);
      end
      if (state_r == bfa_pkg::S_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    issue_r      <= issue_nxt;
    eval_r       <= eval_nxt;
    base_r       <= base_nxt;
    limit_r      <= limit_nxt;
    wdata_r      <= wdata_nxt;
    op_r         <= op_nxt;
    cur_r        <= cur_nxt;
    wr_r         <= wr_nxt;
    kern_r       <= kern_nxt;
    res_frame_r  <= res_frame_nxt;
    res_pres_r   <= res_pres_nxt;
    res_rw_r     <= res_rw_nxt;
    res_usr_r    <= res_usr_nxt;
    res_status_r <= res_status_nxt;
    if (state_r == bfa_pkg::S_EMIT && slot_free) begin
      out_frame_r  <= res_frame_r;
      out_pres_r   <= res_pres_r;
      out_rw_r     <= res_rw_r;
      out_usr_r    <= res_usr_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_frame_out = out_frame_r;
  assign out_present   = out_pres_r;
  assign out_writable  = out_rw_r;
  assign out_user_mode = out_usr_r;
  assign out_status    = out_status_r;

  `BFA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_fire, state_r != bfa_pkg::S_IDLE, "accepted beat did not start work")
  `BFA_ASSERT_NOW(a_clear_blocks_input, clk, rst_n, state_r == bfa_pkg::S_CLEAR, !in_ready, "input taken during clearing pass")
  `BFA_ASSERT_NOW(a_alloc_in_limit, clk, rst_n, state_r == bfa_pkg::S_SCAN && rd_pend_r && alloc_hit, (found_frame < limit_r) && (found_frame != '0), "allocated frame outside search range")
  `BFA_ASSERT_NEXT(a_write_then_emit, clk, rst_n, state_r == bfa_pkg::S_WRITE, state_r == bfa_pkg::S_EMIT, "bitmap write-back not followed by result")

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    bfa_pkg::bfa_op_t            op;
    logic [bfa_pkg::FRAME_W-1:0] frame;
    logic                        wr;
    logic                        kern;
  } page_req_t;

  typedef struct {
    logic [bfa_pkg::FRAME_W-1:0] frame;
    logic                        present;
    logic                        writable;
    logic                        user_mode;
    bfa_pkg::bfa_status_t        status;
  } page_entry_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [bfa_pkg::LIMIT_W-1:0] cfg_frame_count = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        in_operation = 1'b0;
  logic [bfa_pkg::FRAME_W-1:0] in_current_frame = '0;
  logic                        in_want_write = 1'b0;
  logic                        in_is_kernel = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [bfa_pkg::FRAME_W-1:0] out_frame_out;
  logic                        out_present;
  logic                        out_writable;
  logic                        out_user_mode;
  logic [1:0]                  out_status;

  page_req_t                      pending_reqs[$];
  page_entry_t                    expected_entries[$];
  logic [bfa_pkg::FRAME_SPAN-1:0] used_frames = bfa_pkg::FRAME_SPAN'(1);
  logic [bfa_pkg::LIMIT_W-1:0]    frame_limit = bfa_pkg::LIMIT_W'(bfa_pkg::FRAME_SPAN);
  page_req_t                      on_bus;
  page_entry_t                    want;
  bit                             steady_in, steady_out;
  int                             send_gap, hold_cycles;
  int                             reqs_queued, reqs_accepted;
  int                             mismatches, grants, exhausted, no_ops, releases, limit_writes;

  bitmap_frame_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_frame_count  (cfg_frame_count),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_current_frame (in_current_frame),
    .in_want_write    (in_want_write),
    .in_is_kernel     (in_is_kernel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_out    (out_frame_out),
    .out_present      (out_present),
    .out_writable     (out_writable),
    .out_user_mode    (out_user_mode),
    .out_status       (out_status)
  );

  initial forever #4 clk = ~clk;

  function automatic int search_span();
    return (frame_limit > bfa_pkg::FRAME_SPAN) ? bfa_pkg::FRAME_SPAN : int'(frame_limit);
  endfunction

  function automatic page_entry_t map_page(page_req_t r);
    page_entry_t e;
    int          span;
    e.frame = '0;
    e.present = 1'b0;
    e.writable = 1'b0;
    e.user_mode = 1'b0;
    e.status = bfa_pkg::ST_DONE;
    span = search_span();
    if (r.op == bfa_pkg::OP_ALLOC) begin
      if (r.frame != 0) begin
        e.frame = r.frame;
        e.status = bfa_pkg::ST_NOP;
        no_ops++;
      end else begin
        e.status = bfa_pkg::ST_FULL;
        for (int f = 1; f < span && e.status == bfa_pkg::ST_FULL; f++) begin
          if (!used_frames[f]) begin
            used_frames[f] = 1'b1;
            e.frame = bfa_pkg::FRAME_W'(f);
            e.present = 1'b1;
            e.writable = r.wr;
            e.user_mode = !r.kern;
            e.status = bfa_pkg::ST_DONE;
          end
        end
        if (e.status == bfa_pkg::ST_FULL) exhausted++;
        else grants++;
      end
    end else if (r.frame == 0) begin
      e.status = bfa_pkg::ST_NOP;
      no_ops++;
    end else begin
      used_frames[r.frame] = 1'b0;
      releases++;
    end
    return e;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_entries.push_back(map_page(on_bus));
        reqs_accepted++;
        send_gap = steady_in ? 0 : $urandom_range(10);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          on_bus = pending_reqs.pop_front();
          in_operation <= on_bus.op;
          in_current_frame <= on_bus.frame;
          in_want_write <= on_bus.wr;
          in_is_kernel <= on_bus.kern;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_entries.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: frame %0d p%b w%b u%b status %0d", out_frame_out,
                     out_present, out_writable, out_user_mode, out_status);
        end else begin
          want = expected_entries.pop_front();
          if (out_frame_out !== want.frame || out_present !== want.present ||
              out_writable !== want.writable || out_user_mode !== want.user_mode ||
              out_status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected frame %0d p%b w%b u%b status %0d,",
                        " got frame %0d p%b w%b u%b status %0d"},
                       want.frame, want.present, want.writable, want.user_mode,
                       want.status, out_frame_out, out_present, out_writable,
                       out_user_mode, out_status);
          end
        end
        hold_cycles = steady_out ? 0 : $urandom_range(10);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_req(bfa_pkg::bfa_op_t op, int frame, bit wr, bit kern);
    page_req_t r;
    r.op = op;
    r.frame = bfa_pkg::FRAME_W'(frame);
    r.wr = wr;
    r.kern = kern;
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  task automatic wait_drained();
    while (reqs_accepted != reqs_queued || expected_entries.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_frame_count(int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_frame_count <= bfa_pkg::LIMIT_W'(value);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    frame_limit = bfa_pkg::LIMIT_W'(value);
    limit_writes++;
    @(negedge clk);
  endtask

  task automatic queue_random(int n);
    bfa_pkg::bfa_op_t op;
    int               frame;
    int               span;
    span = search_span();
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(99) < 58) ? bfa_pkg::OP_ALLOC : bfa_pkg::OP_FREE;
      case ($urandom_range(9))
        0: frame = $urandom_range(bfa_pkg::FRAME_SPAN - 1);
        1: frame = 0;
        2: frame = (op == bfa_pkg::OP_ALLOC) ? 0 : $urandom_range((span > 65) ? 64 : 1, 1);
        default: begin
          if (op == bfa_pkg::OP_ALLOC) frame = 0;
          else if (span > 1) frame = $urandom_range(span - 1, 1);
          else frame = $urandom_range(bfa_pkg::FRAME_SPAN - 1);
        end
      endcase
      push_req(op, frame, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    int phase_counts[9];
    phase_counts = '{40, 4096, 70, 2, 8191, 33, 200, 4095, 64};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_req(bfa_pkg::OP_ALLOC, 0, 1, 0);
    push_req(bfa_pkg::OP_ALLOC, 0, 0, 1);
    push_req(bfa_pkg::OP_ALLOC, 0, 1, 1);
    push_req(bfa_pkg::OP_ALLOC, 4095, 1, 0);
    push_req(bfa_pkg::OP_ALLOC, 'hAAA, 0, 1);
    push_req(bfa_pkg::OP_FREE, 0, 1, 1);
    push_req(bfa_pkg::OP_FREE, 2, 0, 0);
    push_req(bfa_pkg::OP_ALLOC, 0, 0, 0);
    push_req(bfa_pkg::OP_FREE, 4095, 1, 0);
    push_req(bfa_pkg::OP_FREE, 'h555, 0, 1);
    wait_drained();

    set_frame_count(0);
    push_req(bfa_pkg::OP_ALLOC, 0, 1, 0);
    push_req(bfa_pkg::OP_ALLOC, 'hFFF, 1, 1);
    wait_drained();

    set_frame_count(1);
    push_req(bfa_pkg::OP_ALLOC, 0, 0, 1);
    push_req(bfa_pkg::OP_FREE, 3, 1, 0);
    wait_drained();

    set_frame_count(5);
    push_req(bfa_pkg::OP_ALLOC, 0, 1, 0);
    push_req(bfa_pkg::OP_ALLOC, 0, 0, 0);
    push_req(bfa_pkg::OP_ALLOC, 0, 1, 1);
    push_req(bfa_pkg::OP_FREE, 1, 0, 0);
    push_req(bfa_pkg::OP_ALLOC, 0, 1, 0);
    push_req(bfa_pkg::OP_FREE, 1, 1, 1);
    push_req(bfa_pkg::OP_FREE, 1, 0, 1);
    wait_drained();

    set_frame_count(8191);
    push_req(bfa_pkg::OP_ALLOC, 0, 1, 0);
    push_req(bfa_pkg::OP_ALLOC, 0, 1, 1);
    wait_drained();

    foreach (phase_counts[p]) begin
      set_frame_count(phase_counts[p]);
      steady_in = ($urandom_range(3) == 0);
      steady_out = ($urandom_range(3) == 0);
      queue_random(50);
      wait_drained();
    end

    $display("%0d requests over %0d frame_count writes: %0d grants, %0d exhausted,",
             reqs_accepted, limit_writes, grants, exhausted);
    $display("%0d no-ops, %0d releases", no_ops, releases);
    if (mismatches == 0 && expected_entries.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
